[rtl/sem_pkg.sv]
// sem_pkg: types and constants shared by the sobel edge magnitude block
// no dependencies
`default_nettype none

package sem_pkg;

   localparam int PIX_W    = 8;
   localparam int WIDTH_W  = 11;
   localparam int HEIGHT_W = 16;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd768;

   typedef struct packed {
      logic [PIX_W-1:0] red_in;
      logic [PIX_W-1:0] green_in;
      logic [PIX_W-1:0] blue_in;
      logic             drain;
   } sem_req_type;

   typedef struct packed {
      logic [PIX_W-1:0] red_out;
      logic [PIX_W-1:0] green_out;
      logic [PIX_W-1:0] blue_out;
      logic             frame_last;
   } sem_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_LAUNCH,
      ST_WAIT,
      ST_SEND
   } sem_state_type;

endpackage

`default_nettype wire

[rtl/sem_line_store.sv]
// sem_line_store: two line stores kept side by side in one memory word
// depends on nothing; registered read, one write port
`default_nettype none

module sem_line_store #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 48
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/sem_lane.sv]
// sem_lane: one color channel, sobel sums then bit-serial rounded root
// depends on sem_pkg
`default_nettype none

module sem_lane
   import sem_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [9*PIX_W-1:0] window,
   output logic                    done,
   output logic      [PIX_W-1:0]   magnitude
);

   logic [3:0]               cnt_ff;
   logic [3:0]               cnt_in;
   logic signed [11:0]       gx_ff;
   logic signed [11:0]       gy_ff;
   logic signed [11:0]       gx_in;
   logic signed [11:0]       gy_in;
   logic signed [21:0]       gx_wide;
   logic signed [21:0]       gy_wide;
   logic [21:0]              sum_ff;
   logic [PIX_W-1:0]         root_ff;
   logic [PIX_W-1:0]         trial;
   logic [PIX_W-1:0]         trial_m1;
   logic [2*PIX_W-1:0]       trial_prod;
   logic [2:0]               bit_idx;
   logic signed [11:0]       p [9];

   // unpack window taps, tap 0 is upper left
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         p[i] = signed'({4'd0, window[(8-i)*PIX_W +: PIX_W]});
      end
   end

   // horizontal and vertical sums
   assign gx_in = p[2] - p[0] + ((p[5] - p[3]) <<< 1) + p[8] - p[6];
   assign gy_in = p[6] - p[0] + ((p[7] - p[1]) <<< 1) + p[8] - p[2];

   // sign-extend the sums so the squares keep all their bits
   assign gx_wide = 22'(gx_ff);
   assign gy_wide = 22'(gy_ff);

   // one root bit per step, msb first
   assign bit_idx    = 3'(4'd9 - cnt_ff);
   assign trial      = root_ff | (PIX_W'(1) << bit_idx);
   assign trial_m1   = trial - PIX_W'(1);
   assign trial_prod = trial * trial_m1;

   // step counter
   always_comb begin
      cnt_in = cnt_ff;
      if (start) begin
         cnt_in = 4'd1;
      end else if (cnt_ff == 4'd10) begin
         cnt_in = 4'd0;
      end else if (cnt_ff != 4'd0) begin
         cnt_in = cnt_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 4'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         gx_ff <= gx_in;
         gy_ff <= gy_in;
      end else if (cnt_ff == 4'd1) begin
         sum_ff  <= $unsigned(gx_wide * gx_wide) + $unsigned(gy_wide * gy_wide);
         root_ff <= '0;
      end else if (cnt_ff >= 4'd2 && cnt_ff <= 4'd9) begin
         if (22'(trial_prod) < sum_ff) begin
            root_ff <= trial;
         end
      end
   end

   assign done      = (cnt_ff == 4'd10);
   assign magnitude = root_ff;

endmodule

`default_nettype wire

[rtl/sobel_edge_magnitude_rgb.sv]
// sobel_edge_magnitude_rgb: top level, line stores, window, control, output register
// depends on sem_pkg, sem_line_store, sem_lane
`default_nettype none

// Sobel gradient magnitude on an RGB raster stream, 3x3 window with zero
// padding, one magnitude per channel clamped to 255. An item is taken, the
// line store is read and written, and three channel lanes then run side by
// side: the sums, then the squares, then the root, one bit per cycle. An
// item that closes a row also gives a second result; an item may give no
// result. A new item is taken only when the last is through. Results wait
// in an output register until taken. After the frame, send image_width
// drain items to flush the last row.
module sobel_edge_magnitude_rgb
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire sem_req_type          req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output sem_rsp_type               rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int EW    = (CW > WIDTH_W) ? CW : WIDTH_W;
   localparam int PX_W  = 3 * PIX_W;

   sem_state_type         state_ff;
   sem_state_type         state_in;
   logic [WIDTH_W-1:0]    width_ff;
   logic [HEIGHT_W-1:0]   height_ff;
   logic [COL_W-1:0]      col_ff;
   logic [HEIGHT_W-1:0]   row_ff;
   logic [PX_W-1:0]       pix_ff;
   logic                  flush_ff;
   logic                  e2_ff;
   logic                  sel_ff;
   logic [PX_W-1:0]       win_ff [9];
   sem_rsp_type           rsp_ff;

   logic [EW-1:0]         w_ext;
   logic [EW-1:0]         w_eff;
   logic [EW-1:0]         c_plus;
   logic [HEIGHT_W-1:0]   h_eff;
   logic                  flush_now;
   logic                  accept;
   logic                  ignore;
   logic                  row_end;
   logic                  e1;
   logic                  e2;
   logic                  lane_start;
   logic                  upd;
   logic [2*PX_W-1:0]     rd_data;
   logic [PX_W-1:0]       up_pix;
   logic [PX_W-1:0]       mid_pix;
   logic [PX_W-1:0]       lane_win [9];
   logic [9*PIX_W-1:0]    chan_win [3];
   logic [2:0]            lane_done;
   logic [PIX_W-1:0]      lane_mag [3];

   // effective frame size
   assign w_ext = EW'(width_ff);
   always_comb begin
      if (width_ff == '0) begin
         w_eff = EW'(1);
      end else if (w_ext > EW'(MAX_WIDTH)) begin
         w_eff = EW'(MAX_WIDTH);
      end else begin
         w_eff = w_ext;
      end
   end
   assign h_eff     = (height_ff == '0) ? HEIGHT_W'(1) : height_ff;
   assign flush_now = (row_ff >= h_eff);
   assign c_plus    = EW'(col_ff) + EW'(1);
   assign row_end   = (c_plus >= w_eff);
   assign e1        = (row_ff != '0) && (col_ff != '0);
   assign e2        = (row_ff != '0) && row_end;

   assign accept = req_valid && req_ready;
   assign ignore = !flush_now && req_data.drain;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !ignore) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (e1 || e2) state_in = ST_LAUNCH;
            else state_in = ST_IDLE;
         end
         ST_LAUNCH: state_in = ST_WAIT;
         ST_WAIT: begin
            if (lane_done[0]) state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_ready) begin
               if (!sel_ff && e2_ff) state_in = ST_LAUNCH;
               else state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      lane_start = 1'b0;
      upd        = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready  = 1'b1;
         ST_UPDATE: upd        = 1'b1;
         ST_LAUNCH: lane_start = 1'b1;
         ST_WAIT:   ;
         ST_SEND:   rsp_valid  = 1'b1;
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // position counters, window and control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         sel_ff <= 1'b0;
         e2_ff  <= 1'b0;
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (upd) begin
         e2_ff  <= e2;
         sel_ff <= !e1;
         if (row_end) begin
            col_ff <= '0;
            row_ff <= flush_ff ? '0 : row_ff + HEIGHT_W'(1);
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
         for (int i = 0; i < 3; i++) begin
            if (col_ff == '0) begin
               win_ff[i*3]   <= '0;
               win_ff[i*3+1] <= '0;
            end else begin
               win_ff[i*3]   <= win_ff[i*3+1];
               win_ff[i*3+1] <= win_ff[i*3+2];
            end
         end
         win_ff[2] <= up_pix;
         win_ff[5] <= mid_pix;
         win_ff[8] <= pix_ff;
      end else if (state_ff == ST_SEND && rsp_ready) begin
         sel_ff <= 1'b1;
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (accept) begin
         flush_ff <= flush_now;
         pix_ff   <= flush_now ? '0
                   : {req_data.red_in, req_data.green_in, req_data.blue_in};
      end
   end

   // line stores: upper in the high half, middle in the low half
   sem_line_store #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (2*PX_W)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_data),
      .wr_en   (upd),
      .wr_addr (col_ff),
      .wr_data ({rd_data[PX_W-1:0], pix_ff})
   );

   assign up_pix  = (row_ff >= HEIGHT_W'(2)) ? rd_data[2*PX_W-1:PX_W] : '0;
   assign mid_pix = (row_ff != '0) ? rd_data[PX_W-1:0] : '0;

   // window for the lanes: a row's last result sees the window moved one column right
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (sel_ff) begin
            lane_win[i*3]   = win_ff[i*3+1];
            lane_win[i*3+1] = win_ff[i*3+2];
            lane_win[i*3+2] = '0;
         end else begin
            lane_win[i*3]   = win_ff[i*3];
            lane_win[i*3+1] = win_ff[i*3+1];
            lane_win[i*3+2] = win_ff[i*3+2];
         end
      end
      for (int ch = 0; ch < 3; ch++) begin
         for (int i = 0; i < 9; i++) begin
            chan_win[ch][(8-i)*PIX_W +: PIX_W] = lane_win[i][(2-ch)*PIX_W +: PIX_W];
         end
      end
   end

   // one lane per color channel
   for (genvar ch = 0; ch < 3; ch++) begin : g_lane
      sem_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .start     (lane_start),
         .window    (chan_win[ch]),
         .done      (lane_done[ch]),
         .magnitude (lane_mag[ch])
      );
   end

   // merge the lanes into the output register
   always_ff @(posedge clock) begin
      if (state_ff == ST_WAIT && lane_done[0]) begin
         rsp_ff.red_out    <= lane_mag[0];
         rsp_ff.green_out  <= lane_mag[1];
         rsp_ff.blue_out   <= lane_mag[2];
         rsp_ff.frame_last <= sel_ff && e2_ff && flush_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire
